### hdl/crn_pkg.sv
// Shared types, constants and saturating arithmetic for the Crank-Nicolson row assembler.
package crn_pkg;

  localparam int FRAC_BITS_DEF = 24;
  localparam int VW = 48;
  localparam int CW = 32;
  localparam int NUM_REGS = 5;
  localparam int ADDR_W = 5;

  localparam logic [2:0] REG_VOL  = 3'd0;
  localparam logic [2:0] REG_RATE = 3'd1;
  localparam logic [2:0] REG_DT   = 3'd2;
  localparam logic [2:0] REG_V1   = 3'd3;
  localparam logic [2:0] REG_V2   = 3'd4;

  localparam int OP_W = 4;
  localparam int NUM_OPS = 14;
  localparam logic [OP_W-1:0] OP_VOL2 = 4'd0;
  localparam logic [OP_W-1:0] OP_S2   = 4'd1;
  localparam logic [OP_W-1:0] OP_T1   = 4'd2;
  localparam logic [OP_W-1:0] OP_T2   = 4'd3;
  localparam logic [OP_W-1:0] OP_A    = 4'd4;
  localparam logic [OP_W-1:0] OP_RS   = 4'd5;
  localparam logic [OP_W-1:0] OP_T3   = 4'd6;
  localparam logic [OP_W-1:0] OP_B    = 4'd7;
  localparam logic [OP_W-1:0] OP_RDT  = 4'd8;
  localparam logic [OP_W-1:0] OP_HRDT = 4'd9;
  localparam logic [OP_W-1:0] OP_LT   = 4'd10;
  localparam logic [OP_W-1:0] OP_CM   = 4'd11;
  localparam logic [OP_W-1:0] OP_UN   = 4'd12;
  localparam logic [OP_W-1:0] OP_F    = 4'd13;

  typedef struct packed {
    logic [CW-1:0] vol;
    logic [CW-1:0] rate;
    logic [CW-1:0] dt;
    logic [CW-1:0] v1;
    logic [CW-1:0] v2;
  } cfg_t;

  typedef struct packed {
    logic            capture;
    logic            mul_lo;
    logic            mul_hi;
    logic            wr;
    logic            derive;
    logic            fin1;
    logic            load;
    logic [OP_W-1:0] op;
  } cmd_t;

  typedef struct packed {
    logic row_pending;
    logic out_free;
  } sts_t;

  // Saturate a 49-bit sum or difference back to the signed 48-bit range.
  function automatic logic [VW-1:0] sat_addsub(input logic [VW-1:0] a,
                                               input logic [VW-1:0] b,
                                               input logic sub);
    logic [VW:0] s;
    s = sub ? ({a[VW-1], a} - {b[VW-1], b}) : ({a[VW-1], a} + {b[VW-1], b});
    if (s[VW] != s[VW-1]) begin
      return s[VW] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
    end
    return s[VW-1:0];
  endfunction

endpackage

### hdl/crn_cfg.sv
// APB register bank holding the five coefficient registers.
module crn_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel_i,
  input  logic                       penable_i,
  input  logic                       pwrite_i,
  input  logic [crn_pkg::ADDR_W-1:0] paddr_i,
  input  logic [crn_pkg::CW-1:0]     pwdata_i,
  output logic [crn_pkg::CW-1:0]     prdata_o,
  output logic                       pready_o,
  output crn_pkg::cfg_t              cfg_o
);

  crn_pkg::cfg_t cfg_q;
  logic          wr_en;
  logic [2:0]    idx;

  assign idx = paddr_i[4:2];
  assign wr_en = psel_i & penable_i & pwrite_i;
  assign pready_o = 1'b1;
  assign cfg_o = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      case (idx)
        crn_pkg::REG_VOL:  cfg_q.vol  <= pwdata_i;
        crn_pkg::REG_RATE: cfg_q.rate <= pwdata_i;
        crn_pkg::REG_DT:   cfg_q.dt   <= pwdata_i;
        crn_pkg::REG_V1:   cfg_q.v1   <= pwdata_i;
        crn_pkg::REG_V2:   cfg_q.v2   <= pwdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      crn_pkg::REG_VOL:  prdata_o = cfg_q.vol;
      crn_pkg::REG_RATE: prdata_o = cfg_q.rate;
      crn_pkg::REG_DT:   prdata_o = cfg_q.dt;
      crn_pkg::REG_V1:   prdata_o = cfg_q.v1;
      crn_pkg::REG_V2:   prdata_o = cfg_q.v2;
      default:           prdata_o = '0;
    endcase
  end

endmodule

### hdl/crn_ctrl.sv
// Sequencer that steps the shared multiplier through the row computation.
module crn_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  crn_pkg::sts_t sts_i,
  output crn_pkg::cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MUL0   = 3'd1;
  localparam logic [2:0] ST_MUL1   = 3'd2;
  localparam logic [2:0] ST_WR     = 3'd3;
  localparam logic [2:0] ST_DERIVE = 3'd4;
  localparam logic [2:0] ST_FIN1   = 3'd5;
  localparam logic [2:0] ST_FIN2   = 3'd6;

  logic [2:0]               state_q, state_d;
  logic [crn_pkg::OP_W-1:0] op_q, op_d;

  always_comb begin
    state_d = state_q;
    op_d = op_q;
    cmd_o = '0;
    cmd_o.op = op_q;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i && sts_i.row_pending) begin
          state_d = ST_MUL0;
          op_d = crn_pkg::OP_VOL2;
        end
      end
      ST_MUL0: begin
        cmd_o.mul_lo = 1'b1;
        state_d = ST_MUL1;
      end
      ST_MUL1: begin
        cmd_o.mul_hi = 1'b1;
        state_d = ST_WR;
      end
      ST_WR: begin
        cmd_o.wr = 1'b1;
        if (op_q == crn_pkg::OP_HRDT) begin
          state_d = ST_DERIVE;
        end else if (op_q == crn_pkg::OP_F) begin
          state_d = ST_FIN1;
        end else begin
          op_d = op_q + 4'd1;
          state_d = ST_MUL0;
        end
      end
      ST_DERIVE: begin
        cmd_o.derive = 1'b1;
        op_d = crn_pkg::OP_LT;
        state_d = ST_MUL0;
      end
      ST_FIN1: begin
        cmd_o.fin1 = 1'b1;
        state_d = ST_FIN2;
      end
      ST_FIN2: begin
        cmd_o.load = sts_i.out_free;
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q <= crn_pkg::OP_VOL2;
    end else begin
      state_q <= state_d;
      op_q <= op_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (op_q < 4'(crn_pkg::NUM_OPS)))
    else $error("operation index out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.capture && !sts_i.row_pending) |=> (state_q == ST_IDLE))
    else $error("point without a row started a computation");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DERIVE) |-> ($past(op_q) == crn_pkg::OP_HRDT))
    else $error("derive step out of order");

endmodule

### hdl/crn_dp.sv
// Datapath: point window, shared fixed-point multiplier, temporaries and output register.
module crn_dp #(
  parameter int FRAC_BITS = crn_pkg::FRAC_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  crn_pkg::cfg_t          cfg_i,
  input  crn_pkg::cmd_t          cmd_i,
  output crn_pkg::sts_t          sts_o,
  input  logic [crn_pkg::VW-1:0] asset_i,
  input  logic [crn_pkg::VW-1:0] option_i,
  input  logic                   point_last_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [crn_pkg::VW-1:0] diag_o,
  output logic [crn_pkg::VW-1:0] upper_o,
  output logic [crn_pkg::VW-1:0] lower_o,
  output logic [crn_pkg::VW-1:0] target_o,
  output logic                   row_last_o
);

  localparam int VW = crn_pkg::VW;
  localparam int HW = VW / 2;
  localparam int PW = 2 * VW;
  localparam logic [VW-1:0] ONE  = VW'(1) << FRAC_BITS;
  localparam logic [VW-1:0] HALF = VW'(1) << (FRAC_BITS - 1);
  localparam logic [VW-1:0] QTR  = VW'(1) << (FRAC_BITS - 2);
  localparam logic [VW-1:0] NEG_ONE = ~ONE + VW'(1);
  localparam logic [PW-1:0] LIM_POS = PW'({1'b0, {(VW-1){1'b1}}});
  localparam logic [PW-1:0] LIM_NEG = PW'({1'b1, {(VW-1){1'b0}}});

  // Grid window and points counter.
  logic [VW-1:0] older_q, middle_q, mid_asset_q;
  logic [1:0]    pts_q;

  // Operands of the row being assembled.
  logic [VW-1:0] s_q, vold_q, vmid_q, vnew_q;
  logic          first_q, last_q;

  logic [VW-1:0] res_q [crn_pkg::NUM_OPS];
  logic [VW-1:0] upper_q, lower_q, diag_q, centre_q, omr_q, tgt_q;
  logic [PW-1:0] acc_q;

  logic                   out_valid_q;
  logic [VW-1:0]          diag_out_q, upper_out_q, lower_out_q, target_out_q;
  logic                   row_last_q;

  logic [VW-1:0]   x, y, ux, uy, fres, res_mag;
  logic            neg;
  logic [HW-1:0]   y_part;
  logic [VW+HW-1:0] pp;
  logic [PW-1:0]   mag, lim;
  logic [VW-1:0]   twoa, t0, up2;
  logic [VW+1:0]   t0_wide;

  assign sts_o.row_pending = pts_q[1];
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_comb begin
    case (cmd_i.op)
      crn_pkg::OP_VOL2: begin x = VW'(cfg_i.vol);  y = VW'(cfg_i.vol); end
      crn_pkg::OP_S2:   begin x = s_q;             y = s_q; end
      crn_pkg::OP_T1:   begin x = res_q[crn_pkg::OP_VOL2]; y = res_q[crn_pkg::OP_S2]; end
      crn_pkg::OP_T2:   begin x = VW'(cfg_i.v1);   y = res_q[crn_pkg::OP_T1]; end
      crn_pkg::OP_A:    begin x = QTR;             y = res_q[crn_pkg::OP_T2]; end
      crn_pkg::OP_RS:   begin x = VW'(cfg_i.rate); y = s_q; end
      crn_pkg::OP_T3:   begin x = VW'(cfg_i.v2);   y = res_q[crn_pkg::OP_RS]; end
      crn_pkg::OP_B:    begin x = QTR;             y = res_q[crn_pkg::OP_T3]; end
      crn_pkg::OP_RDT:  begin x = VW'(cfg_i.rate); y = VW'(cfg_i.dt); end
      crn_pkg::OP_HRDT: begin x = HALF;            y = res_q[crn_pkg::OP_RDT]; end
      crn_pkg::OP_LT:   begin x = lower_q;         y = vold_q; end
      crn_pkg::OP_CM:   begin x = centre_q;        y = vmid_q; end
      crn_pkg::OP_UN:   begin x = upper_q;         y = vnew_q; end
      crn_pkg::OP_F:    begin x = res_q[crn_pkg::OP_LT]; y = omr_q; end
      default:          begin x = '0;              y = '0; end
    endcase
  end

  // Magnitude product in two halves, truncated toward zero, then saturated.
  always_comb begin
    neg = x[VW-1] ^ y[VW-1];
    ux = x[VW-1] ? (~x + VW'(1)) : x;
    uy = y[VW-1] ? (~y + VW'(1)) : y;
    y_part = cmd_i.mul_hi ? uy[VW-1:HW] : uy[HW-1:0];
    pp = ux * y_part;
    mag = acc_q >> FRAC_BITS;
    lim = neg ? LIM_NEG : LIM_POS;
    res_mag = (mag > lim) ? lim[VW-1:0] : mag[VW-1:0];
    fres = neg ? (~res_mag + VW'(1)) : res_mag;
  end

  always_comb begin
    twoa = crn_pkg::sat_addsub(res_q[crn_pkg::OP_A], res_q[crn_pkg::OP_A], 1'b0);
    t0_wide = -{{2{res_q[crn_pkg::OP_LT][VW-1]}}, res_q[crn_pkg::OP_LT]}
              - {{2{res_q[crn_pkg::OP_CM][VW-1]}}, res_q[crn_pkg::OP_CM]};
    if (t0_wide[VW+1:VW-1] != {3{t0_wide[VW+1]}}) begin
      t0 = t0_wide[VW+1] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
    end else begin
      t0 = t0_wide[VW-1:0];
    end
    up2 = crn_pkg::sat_addsub(upper_q, upper_q, 1'b0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      older_q <= '0;
      middle_q <= '0;
      mid_asset_q <= '0;
      pts_q <= '0;
    end else if (cmd_i.capture) begin
      if (point_last_i) begin
        older_q <= '0;
        middle_q <= '0;
        mid_asset_q <= '0;
        pts_q <= '0;
      end else begin
        older_q <= middle_q;
        middle_q <= option_i;
        mid_asset_q <= asset_i;
        if (pts_q != 2'd3) begin
          pts_q <= pts_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      s_q <= mid_asset_q;
      vold_q <= older_q;
      vmid_q <= middle_q;
      vnew_q <= option_i;
      first_q <= (pts_q == 2'd2);
      last_q <= point_last_i;
    end
    if (cmd_i.mul_lo) begin
      acc_q <= PW'(pp);
    end
    if (cmd_i.mul_hi) begin
      acc_q <= acc_q + (PW'(pp) << HW);
    end
    if (cmd_i.wr) begin
      res_q[cmd_i.op] <= fres;
    end
    if (cmd_i.derive) begin
      upper_q <= crn_pkg::sat_addsub(res_q[crn_pkg::OP_A], res_q[crn_pkg::OP_B], 1'b0);
      lower_q <= crn_pkg::sat_addsub(res_q[crn_pkg::OP_A], res_q[crn_pkg::OP_B], 1'b1);
      diag_q <= crn_pkg::sat_addsub(crn_pkg::sat_addsub(NEG_ONE, twoa, 1'b1),
                                    res_q[crn_pkg::OP_HRDT], 1'b1);
      centre_q <= crn_pkg::sat_addsub(crn_pkg::sat_addsub(ONE, twoa, 1'b1),
                                      res_q[crn_pkg::OP_HRDT], 1'b1);
      omr_q <= crn_pkg::sat_addsub(ONE, res_q[crn_pkg::OP_RDT], 1'b1);
    end
    if (cmd_i.fin1) begin
      tgt_q <= crn_pkg::sat_addsub(t0, res_q[crn_pkg::OP_UN], 1'b1);
    end
    if (cmd_i.load) begin
      target_out_q <= first_q ? crn_pkg::sat_addsub(tgt_q, res_q[crn_pkg::OP_F], 1'b1)
                              : tgt_q;
      diag_out_q <= last_q ? crn_pkg::sat_addsub(diag_q, up2, 1'b0) : diag_q;
      upper_out_q <= last_q ? '0 : upper_q;
      if (first_q) begin
        lower_out_q <= '0;
      end else begin
        lower_out_q <= last_q ? crn_pkg::sat_addsub(lower_q, upper_q, 1'b1) : lower_q;
      end
      row_last_q <= last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign diag_o = diag_out_q;
  assign upper_o = upper_out_q;
  assign lower_o = lower_out_q;
  assign target_o = target_out_q;
  assign row_last_o = row_last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten while a result waits");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.capture && point_last_i) |=> (pts_q == 2'd0))
    else $error("window not cleared after the last point");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.capture |-> !(cmd_i.mul_lo || cmd_i.mul_hi || cmd_i.wr))
    else $error("new point captured during a multiply");

endmodule

### hdl/crank_nicolson_row_assembly.sv
// Top level of the Crank-Nicolson tridiagonal row assembler.
// Grid points enter on the s_axis channel, lowest asset price first, with
// tlast on the upper boundary point. Once two points of a grid are held,
// each further point yields the tridiagonal row of the point before it on
// the m_axis channel; tlast there marks the final interior row.
// Coefficients come from the APB registers (volatility, rate, time step and the
// two term scales); the user must write them only while the block is idle, which
// the block itself does not enforce. A point that completes no row is captured
// while the block stays idle. A point that yields a row occupies the block while
// fourteen fixed-point products run one after another on a single shared
// multiplier, each in two 48x24 halves plus a saturating write-back, then a
// derive step and the finishing states FIN1 and FIN2. The next point is accepted
// right after the row lands in the output register, so a result waiting on a
// stalled receiver does not block input until the following row is ready to be
// loaded; that row then waits until the receiver takes the earlier one.
// Reset clears the point window, the registers and the output valid.
module crank_nicolson_row_assembly #(
  parameter int FRAC_BITS = crn_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // asset_price [47:0], option_price [95:48]
  input  logic [95:0]                s_axis_tdata_i,
  input  logic                       s_axis_tlast_i,
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  // diag_coef [47:0], upper_coef [95:48], lower_coef [143:96], target_value [191:144]
  output logic [191:0]               m_axis_tdata_o,
  output logic                       m_axis_tlast_o,
  input  logic                       psel_i,
  input  logic                       penable_i,
  input  logic                       pwrite_i,
  input  logic [crn_pkg::ADDR_W-1:0] paddr_i,
  input  logic [crn_pkg::CW-1:0]     pwdata_i,
  output logic [crn_pkg::CW-1:0]     prdata_o,
  output logic                       pready_o
);

  crn_pkg::cfg_t cfg;
  crn_pkg::cmd_t cmd;
  crn_pkg::sts_t sts;

  crn_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel_i),
    .penable_i (penable_i),
    .pwrite_i  (pwrite_i),
    .paddr_i   (paddr_i),
    .pwdata_i  (pwdata_i),
    .prdata_o  (prdata_o),
    .pready_o  (pready_o),
    .cfg_o     (cfg)
  );

  crn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  crn_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .asset_i      (s_axis_tdata_i[47:0]),
    .option_i     (s_axis_tdata_i[95:48]),
    .point_last_i (s_axis_tlast_i),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .diag_o       (m_axis_tdata_o[47:0]),
    .upper_o      (m_axis_tdata_o[95:48]),
    .lower_o      (m_axis_tdata_o[143:96]),
    .target_o     (m_axis_tdata_o[191:144]),
    .row_last_o   (m_axis_tlast_o)
  );

endmodule
